// File: design/mih_pkg.sv
// ----------------------------------------------------------------------------
// mih_pkg: shared types and constants for the MurmurHash3 ID hasher
// Hash constants, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package mih_pkg;

   // MurmurHash3 x86_32 mixing constants
   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

   // exponent clamp bounds for the ID word
   localparam logic [7:0] EXP_MIN = 8'd1;
   localparam logic [7:0] EXP_MAX = 8'd254;

   // byte count held when the next byte completes a block
   localparam logic [1:0] PHASE_FULL = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_BLK_C2,
      ST_BLK_MIX,
      ST_TAIL_C1,
      ST_TAIL_C2,
      ST_FIN_XOR,
      ST_FIN_M1,
      ST_FIN_M2,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_ABSORB,
      OP_MUL_C2,
      OP_MIX,
      OP_TAIL_C1,
      OP_FIN_XOR,
      OP_FIN_M1,
      OP_FIN_M2,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic block_done;   // captured word completes a 4-byte block
      logic last_item;    // captured word closes the name
      logic out_free;     // output register can take a result
   } status_type;

endpackage

// File: design/mih_req_if.sv
// ----------------------------------------------------------------------------
// mih_req_if: byte channel into the hasher
// valid/ready handshake carrying one name byte with its flags.
// ----------------------------------------------------------------------------
interface mih_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output data_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last,
                   output ready);
endinterface

// File: design/mih_rsp_if.sv
// ----------------------------------------------------------------------------
// mih_rsp_if: result channel out of the hasher
// valid/ready handshake carrying the hash and the matte ID word.
// ----------------------------------------------------------------------------
interface mih_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   logic [31:0] matte_id_bits;

   modport source (output valid, output hash_value, output matte_id_bits,
                   input ready);
   modport sink   (input valid, input hash_value, input matte_id_bits,
                   output ready);
endinterface

// File: design/murmur3_id_hasher_unit.sv
// ----------------------------------------------------------------------------
// murmur3_id_hasher_unit: streaming MurmurHash3 x86_32 with matte ID word
//
// A name enters on req_ch one byte per word (has_byte=1); the word with
// last=1 closes it, and a word with has_byte=0 and last=1 ends the name
// without a byte. Words with both flags low are dropped. Each closed name
// yields one word on rsp_ch: the hash and the hash with its float exponent
// clamped to 1..254. csr_write_data loads the seed; the user is to write it
// only while the block is idle, as the block does not enforce this; it
// applies from the next name start. Sequence: a word passes through capture
// and absorb; a word that completes a 4-byte block then runs c2 and the mix,
// the shared multiplier having run c1 in absorb. A last word adds the tail
// multiplies, length fold and fmix multiplies before the output register.
// The result sits in an output register; a stalled receiver holds it,
// and the next name is accepted meanwhile until another result is ready.
// Reset clears the seed to 0, empties the output and starts a new name.
// ----------------------------------------------------------------------------
module murmur3_id_hasher_unit
   import mih_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_en,
   input  logic [31:0]  csr_write_data,
   mih_req_if.sink      req_ch,
   mih_rsp_if.source    rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   mih_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hash datapath
   mih_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .data_byte      (req_ch.data_byte),
      .has_byte       (req_ch.has_byte),
      .last           (req_ch.last),
      .rsp_ready      (rsp_ch.ready),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_ch.valid),
      .hash_value     (rsp_ch.hash_value),
      .matte_id_bits  (rsp_ch.matte_id_bits)
   );

endmodule

// File: design/mih_ctrl.sv
// ----------------------------------------------------------------------------
// mih_ctrl: sequencer for the hasher datapath
// Steps each word through absorb, block mix and finalization.
// ----------------------------------------------------------------------------
module mih_ctrl
   import mih_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NOP;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            cmd.op = OP_ABSORB;
            if (status.block_done) begin
               state_in = ST_BLK_C2;
            end else if (status.last_item) begin
               state_in = ST_TAIL_C1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BLK_C2: begin
            cmd.op   = OP_MUL_C2;
            state_in = ST_BLK_MIX;
         end
         ST_BLK_MIX: begin
            cmd.op   = OP_MIX;
            state_in = status.last_item ? ST_TAIL_C1 : ST_IDLE;
         end
         ST_TAIL_C1: begin
            cmd.op   = OP_TAIL_C1;
            state_in = ST_TAIL_C2;
         end
         ST_TAIL_C2: begin
            cmd.op   = OP_MUL_C2;
            state_in = ST_FIN_XOR;
         end
         ST_FIN_XOR: begin
            cmd.op   = OP_FIN_XOR;
            state_in = ST_FIN_M1;
         end
         ST_FIN_M1: begin
            cmd.op   = OP_FIN_M1;
            state_in = ST_FIN_M2;
         end
         ST_FIN_M2: begin
            cmd.op   = OP_FIN_M2;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/mih_datapath.sv
// ----------------------------------------------------------------------------
// mih_datapath: hash state, shared multiplier and output register
// One 32x32 multiplier, registered, serves block, tail and finalizer.
// ----------------------------------------------------------------------------
module mih_datapath
   import mih_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic [7:0]  data_byte,
   input  logic        has_byte,
   input  logic        last,
   input  logic        rsp_ready,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   output logic [31:0] hash_value,
   output logic [31:0] matte_id_bits
);

   logic [31:0] seed_ff;
   logic [7:0]  byte_ff, byte_in;
   logic        has_ff, has_in;
   logic        last_ff, last_in;
   logic [31:0] hash_ff, hash_in;
   logic [23:0] part_ff, part_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] length_ff, length_in;
   logic        start_ff, start_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] hout_ff, hout_in;
   logic [31:0] idout_ff, idout_in;
   logic        valid_ff, valid_in;

   logic [31:0] hash_eff, length_eff;
   logic [23:0] part_eff;
   logic [1:0]  phase_eff;
   logic [31:0] mul_a, mul_b, mul_lo;
   logic [31:0] mix_x, fin_t, fin_h;
   logic [7:0]  exp_raw, exp_clamped;

   // state seen by a word: a new name starts from the seed
   assign hash_eff   = start_ff ? seed_ff : hash_ff;
   assign part_eff   = start_ff ? '0 : part_ff;
   assign phase_eff  = start_ff ? '0 : phase_ff;
   assign length_eff = start_ff ? '0 : length_ff;

   assign status.block_done = has_ff && (phase_eff == PHASE_FULL);
   assign status.last_item  = last_ff;
   assign status.out_free   = !valid_ff || rsp_ready;

   // shared multiplier, low half only
   assign mul_lo = mul_a * mul_b;

   // rotl13 of h ^ k, then h*5 + add
   assign mix_x = {hash_ff[18:0] ^ prod_ff[18:0], hash_ff[31:19] ^ prod_ff[31:19]};

   // tail and length fold for the first fmix shift
   assign fin_t = hash_ff ^ ((phase_ff != '0) ? prod_ff : '0) ^ length_ff;

   // last fmix shift and exponent clamp
   assign fin_h   = prod_ff ^ {16'h0, prod_ff[31:16]};
   assign exp_raw = fin_h[30:23];
   always_comb begin
      if (exp_raw < EXP_MIN) begin
         exp_clamped = EXP_MIN;
      end else if (exp_raw > EXP_MAX) begin
         exp_clamped = EXP_MAX;
      end else begin
         exp_clamped = exp_raw;
      end
   end

   // datapath operations
   always_comb begin
      byte_in   = byte_ff;
      has_in    = has_ff;
      last_in   = last_ff;
      hash_in   = hash_ff;
      part_in   = part_ff;
      phase_in  = phase_ff;
      length_in = length_ff;
      start_in  = start_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      hout_in   = hout_ff;
      idout_in  = idout_ff;
      mul_a     = prod_ff;
      mul_b     = MIX_C2;
      valid_in  = rsp_ready ? 1'b0 : valid_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            byte_in = data_byte;
            has_in  = has_byte;
            last_in = last;
         end
         OP_ABSORB: begin
            // idle words leave the state alone
            if (has_ff || last_ff) begin
               start_in  = last_ff;
               hash_in   = hash_eff;
               part_in   = part_eff;
               phase_in  = phase_eff;
               length_in = length_eff;
               if (has_ff) begin
                  length_in = length_eff + 32'd1;
                  case (phase_eff)
                     2'd0: begin
                        part_in[7:0] = byte_ff;
                        phase_in     = 2'd1;
                     end
                     2'd1: begin
                        part_in[15:8] = byte_ff;
                        phase_in      = 2'd2;
                     end
                     2'd2: begin
                        part_in[23:16] = byte_ff;
                        phase_in       = 2'd3;
                     end
                     default: begin
                        // block complete: start k1 = block * c1
                        mul_a    = {byte_ff, part_eff};
                        mul_b    = MIX_C1;
                        prod_in  = mul_lo;
                        part_in  = '0;
                        phase_in = '0;
                     end
                  endcase
               end
            end
         end
         OP_MUL_C2: begin
            mul_a   = {prod_ff[16:0], prod_ff[31:17]};
            mul_b   = MIX_C2;
            prod_in = mul_lo;
         end
         OP_MIX: begin
            hash_in = mix_x + {mix_x[29:0], 2'b00} + MIX_ADD;
         end
         OP_TAIL_C1: begin
            mul_a   = {8'h00, part_ff};
            mul_b   = MIX_C1;
            prod_in = mul_lo;
         end
         OP_FIN_XOR: begin
            acc_in = fin_t ^ {16'h0, fin_t[31:16]};
         end
         OP_FIN_M1: begin
            mul_a   = acc_ff;
            mul_b   = FIN_M1;
            prod_in = mul_lo;
         end
         OP_FIN_M2: begin
            mul_a   = prod_ff ^ {13'h0, prod_ff[31:13]};
            mul_b   = FIN_M2;
            prod_in = mul_lo;
         end
         OP_EMIT: begin
            hout_in  = fin_h;
            idout_in = {fin_h[31], exp_clamped, fin_h[22:0]};
            valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         start_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            seed_ff <= csr_write_data;
         end
         start_ff <= start_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      has_ff    <= has_in;
      last_ff   <= last_in;
      hash_ff   <= hash_in;
      part_ff   <= part_in;
      phase_ff  <= phase_in;
      length_ff <= length_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      hout_ff   <= hout_in;
      idout_ff  <= idout_in;
   end

   assign rsp_valid     = valid_ff;
   assign hash_value    = hout_ff;
   assign matte_id_bits = idout_ff;

endmodule
